### rtl/sdm_pkg.sv
// Shared types and constants for the surround to stereo downmix block.
`timescale 1ns / 1ps
`default_nettype none

package sdm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 15;
  localparam int Q_FRAC   = 14;
  localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
  localparam int ACC_W    = PROD_W + 2;
  localparam int NUM_CHAN = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] GAIN_FRONT_RST  = GAIN_W'(16384);
  localparam logic [GAIN_W-1:0] GAIN_REAR_RST   = GAIN_W'(11469);
  localparam logic [GAIN_W-1:0] GAIN_CENTER_RST = GAIN_W'(8192);
  localparam logic [GAIN_W-1:0] GAIN_LFE_RST    = GAIN_W'(11469);

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FRONT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_REAR   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CENTER = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LFE    = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    LAYOUT_MONO     = 2'd0,
    LAYOUT_STEREO   = 2'd1,
    LAYOUT_SURROUND = 2'd2
  } layout_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0] gain_t;

  // What travels beside the lanes to the merge stage.
  typedef struct packed {
    logic    valid;
    layout_t layout;
    sample_t chan0;
    sample_t chan1;
    logic    last;
  } frame_info_t;

endpackage

`default_nettype wire

### rtl/sdm_lane.sv
// One mixing lane: four gain products, then a truncating divide and clip.
`timescale 1ns / 1ps
`default_nettype none

module sdm_lane
  import sdm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    load,
  input  wire sample_t front,
  input  wire sample_t rear,
  input  wire sample_t center,
  input  wire sample_t lfe,
  input  wire gain_t   gain_front,
  input  wire gain_t   gain_rear,
  input  wire gain_t   gain_center,
  input  wire gain_t   gain_lfe,
  output sample_t      mix
);

  logic signed [PROD_W-1:0] prod_front;
  logic signed [PROD_W-1:0] prod_rear;
  logic signed [PROD_W-1:0] prod_center;
  logic signed [PROD_W-1:0] prod_lfe;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  biased;
  logic signed [ACC_W-Q_FRAC-1:0] quot;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_front  <= front  * $signed({1'b0, gain_front});
      prod_rear   <= rear   * $signed({1'b0, gain_rear});
      prod_center <= center * $signed({1'b0, gain_center});
      prod_lfe    <= lfe    * $signed({1'b0, gain_lfe});
    end
  end

  always_comb begin
    acc = ACC_W'(prod_front) + ACC_W'(prod_rear) + ACC_W'(prod_center) + ACC_W'(prod_lfe);
    // bias negatives so the shift rounds toward zero
    biased = acc + (acc[ACC_W-1] ? ACC_W'((1 << Q_FRAC) - 1) : ACC_W'(0));
    quot = biased[ACC_W-1:Q_FRAC];
    if (quot > (ACC_W-Q_FRAC)'(32767)) begin
      mix = sample_t'(16'sh7FFF);
    end else if (quot < -(ACC_W-Q_FRAC)'(32768)) begin
      mix = sample_t'(16'sh8000);
    end else begin
      mix = quot[SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/sdm_merge.sv
// Merge stage: picks the pair for the layout and holds the output word.
`timescale 1ns / 1ps
`default_nettype none

module sdm_merge
  import sdm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire frame_info_t info,
  input  wire sample_t     mix_left,
  input  wire sample_t     mix_right,
  output logic             advance,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [2*SAMPLE_W-1:0] m_tdata, // left_out, right_out
  output logic             m_tlast       // block_end
);

  sample_t left_sel;
  sample_t right_sel;

  assign advance = info.valid && (!m_tvalid || m_tready);

  always_comb begin
    unique case (info.layout)
      LAYOUT_MONO: begin
        left_sel  = info.chan0;
        right_sel = info.chan0;
      end
      LAYOUT_STEREO: begin
        left_sel  = info.chan0;
        right_sel = info.chan1;
      end
      LAYOUT_SURROUND: begin
        left_sel  = mix_left;
        right_sel = mix_right;
      end
      default: begin
        left_sel  = mix_left;
        right_sel = mix_right;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {right_sel, left_sel};
      m_tlast <= info.last;
    end
  end

endmodule

`default_nettype wire

### rtl/surround_to_stereo_downmix_top.sv
// Top level of the surround to stereo downmix: gain registers, lanes and merge.
`timescale 1ns / 1ps
`default_nettype none

// Takes one 16-bit sample frame per word and gives one stereo pair. Layout
// (s_tuser) 0 copies chan0 to both sides, 1 passes chan0/chan1 through, 2 mixes
// 5.1 with the four Q1.14 gain registers (index 0 front, 1 rear, 2 center,
// 3 LFE); layout 3 is dropped with its tlast. Two lanes (left, right) run in
// parallel: registered products, then sum, truncate toward zero and clip in
// the merge stage. Accepted words pass the product/info and output registers;
// one word is accepted every cycle while the output is taken. The user must
// write gains only while the block is idle; the block does not enforce this.
module surround_to_stereo_downmix_top
  import sdm_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [NUM_CHAN*SAMPLE_W-1:0] s_tdata, // chan0 .. chan5
  input  wire logic [1:0]                s_tuser,  // layout
  input  wire logic                      s_tlast,  // frame_end
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [2*SAMPLE_W-1:0]          m_tdata,  // left_out, right_out
  output logic                           m_tlast,  // block_end
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  gain_t       gain_front;
  gain_t       gain_rear;
  gain_t       gain_center;
  gain_t       gain_lfe;
  frame_info_t info;
  logic        advance;
  logic        accept;
  sample_t     chan [NUM_CHAN];
  sample_t     mix_left;
  sample_t     mix_right;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_front  <= GAIN_FRONT_RST;
      gain_rear   <= GAIN_REAR_RST;
      gain_center <= GAIN_CENTER_RST;
      gain_lfe    <= GAIN_LFE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_FRONT:  gain_front  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_REAR:   gain_rear   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_CENTER: gain_center <= cfg_data[GAIN_W-1:0];
        REG_GAIN_LFE:    gain_lfe    <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < NUM_CHAN; i++) begin : g_chan
    assign chan[i] = s_tdata[i*SAMPLE_W +: SAMPLE_W];
  end

  assign s_tready = !info.valid || advance;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      info.layout <= layout_t'(s_tuser);
      info.chan0  <= chan[0];
      info.chan1  <= chan[1];
      info.last   <= s_tlast;
    end
    if (rst) begin
      info.valid <= 1'b0;
    end else if (accept) begin
      // layout 3 yields nothing
      info.valid <= (s_tuser == LAYOUT_MONO) || (s_tuser == LAYOUT_STEREO)
                    || (s_tuser == LAYOUT_SURROUND);
    end else if (advance) begin
      info.valid <= 1'b0;
    end
  end

  sdm_lane u_lane_left (
    .clk         (clk),
    .load        (accept),
    .front       (chan[1]),
    .rear        (chan[3]),
    .center      (chan[0]),
    .lfe         (chan[5]),
    .gain_front  (gain_front),
    .gain_rear   (gain_rear),
    .gain_center (gain_center),
    .gain_lfe    (gain_lfe),
    .mix         (mix_left)
  );

  sdm_lane u_lane_right (
    .clk         (clk),
    .load        (accept),
    .front       (chan[2]),
    .rear        (chan[4]),
    .center      (chan[0]),
    .lfe         (chan[5]),
    .gain_front  (gain_front),
    .gain_rear   (gain_rear),
    .gain_center (gain_center),
    .gain_lfe    (gain_lfe),
    .mix         (mix_right)
  );

  sdm_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .info      (info),
    .mix_left  (mix_left),
    .mix_right (mix_right),
    .advance   (advance),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire
